/* hdl/fpha_pkg.sv */
`default_nettype none
package fpha_pkg;

   localparam int SEG_IDX_W = 10;

   localparam logic [1:0] FUNC_ALLOC  = 2'd0;
   localparam logic [1:0] FUNC_FREE   = 2'd1;
   localparam logic [1:0] FUNC_DEFRAG = 2'd2;
   localparam logic [1:0] FUNC_NOP    = 2'd3;

   localparam logic [1:0] MODE_FIRST = 2'd0;
   localparam logic [1:0] MODE_BEST  = 2'd1;
   localparam logic [1:0] MODE_WORST = 2'd2;
   localparam logic [1:0] MODE_NONE  = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_SIZE = 3'd1;
   localparam logic [2:0] ST_NO_FIT   = 3'd2;
   localparam logic [2:0] ST_RANGE    = 3'd3;
   localparam logic [2:0] ST_NOT_ALLOC = 3'd4;

   localparam logic [1:0] CSR_ALLOC_MODE = 2'd0;
   localparam logic [1:0] CSR_HEAP_SIZE  = 2'd1;

   typedef struct packed {
      logic [15:0] offset;
      logic [16:0] size;
      logic        free;
   } seg_type;

   typedef struct packed {
      logic                 we;
      logic [SEG_IDX_W-1:0] waddr;
      seg_type              wdata;
      logic [SEG_IDX_W-1:0] raddr;
   } mem_req_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH,
      S_A_RD, S_A_CHK, S_A_DEC, S_A_SH_RD, S_A_SH_WR, S_A_W1, S_A_W2,
      S_F_RD, S_F_CHK, S_F_NXT, S_F_NXT_CHK, S_F_PRV, S_F_PRV_CHK,
      S_D_CUR, S_D_LOOP, S_D_CHK,
      S_DROP_RD, S_DROP_WR, S_RESP
   } state_type;

endpackage
`default_nettype wire

/* hdl/fpha_seg_mem.sv */
`default_nettype none
module fpha_seg_mem #(
   parameter int DEPTH = 64
) (
   input  wire logic                 clock,
   input  wire fpha_pkg::mem_req_type mem_req,
   output fpha_pkg::seg_type         rdata
);
   import fpha_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   seg_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr[IW-1:0]] <= mem_req.wdata;
      end
      rdata <= mem[mem_req.raddr[IW-1:0]];
   end

endmodule
`default_nettype wire

/* hdl/fpha_ctrl.sv */
`default_nettype none
module fpha_ctrl #(
   parameter int HEADER_BYTES = 16,
   parameter int MAX_SEGMENTS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  init_req,
   input  wire logic [1:0]            alloc_mode,
   input  wire logic [16:0]           heap_size,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [1:0]            func,
   input  wire logic [15:0]           req_size,
   input  wire logic [15:0]           addr,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [2:0]                 status,
   output logic [15:0]                addr_res,
   output fpha_pkg::mem_req_type      mem_req,
   input  wire fpha_pkg::seg_type     rdata
);
   import fpha_pkg::*;

   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam logic [16:0] HDR = 17'(HEADER_BYTES);
   localparam logic [CW:0] MAXC = (CW+1)'(MAX_SEGMENTS);

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, cnt_ff, cnt_in, pick_ff, pick_in;
   logic [1:0] func_ff, func_in;
   logic [15:0] need_ff, need_in, addr_ff, addr_in;
   logic found_ff, found_in, pend_ff, pend_in;
   logic [15:0] poff_ff, poff_in;
   logic [16:0] psize_ff, psize_in;
   seg_type cur_ff, cur_in;
   logic [2:0] st_ff, st_in;
   logic [15:0] res_ff, res_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_status_ff, rsp_status_in;
   logic [15:0] rsp_addr_ff, rsp_addr_in;

   logic [CW:0] i1, j1, cnt1;
   logic qual, better, done;
   logic [16:0] plus_hdr;
   seg_type wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff <= S_IDLE;
         cnt_ff <= CW'(1);
         pend_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         cnt_ff <= cnt_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      pick_ff <= pick_in;
      func_ff <= func_in;
      need_ff <= need_in;
      addr_ff <= addr_in;
      found_ff <= found_in;
      poff_ff <= poff_in;
      psize_ff <= psize_in;
      cur_ff <= cur_in;
      st_ff <= st_in;
      res_ff <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff <= rsp_addr_in;
   end

   assign req_tready = (state_ff == S_IDLE) && !pend_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign status = rsp_status_ff;
   assign addr_res = rsp_addr_ff;

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      i_in = i_ff;
      j_in = j_ff;
      cnt_in = cnt_ff;
      pick_in = pick_ff;
      func_in = func_ff;
      need_in = need_ff;
      addr_in = addr_ff;
      found_in = found_ff;
      pend_in = pend_ff || init_req;
      poff_in = poff_ff;
      psize_in = psize_ff;
      cur_in = cur_ff;
      st_in = st_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in = rsp_addr_ff;
      mem_req = '0;
      wr = '0;
      i1 = (CW+1)'(i_ff) + 1'b1;
      j1 = (CW+1)'(j_ff) + 1'b1;
      cnt1 = (CW+1)'(cnt_ff);
      qual = rdata.free && (rdata.size >= {1'b0, need_ff});
      better = 1'b0;
      done = 1'b0;
      plus_hdr = 17'(rdata.offset) + HDR;

      unique case (state_ff)
         S_IDLE: begin
            if (pend_ff) begin
               wr.offset = '0;
               wr.size = heap_size - HDR;
               wr.free = 1'b1;
               mem_req.we = 1'b1;
               mem_req.wdata = wr;
               cnt_in = CW'(1);
               pend_in = init_req;
            end else if (req_tvalid) begin
               func_in = func;
               need_in = req_size;
               addr_in = addr;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            st_in = ST_OK;
            res_in = '0;
            i_in = '0;
            found_in = 1'b0;
            state_in = S_RESP;
            unique case (func_ff)
               FUNC_ALLOC: begin
                  if (need_ff == '0) begin
                     st_in = ST_BAD_SIZE;
                  end else begin
                     state_in = S_A_RD;
                  end
               end
               FUNC_FREE: begin
                  if ((17'(addr_ff) < HDR) || (17'(addr_ff) >= heap_size)) begin
                     st_in = ST_RANGE;
                  end else begin
                     state_in = S_F_RD;
                  end
               end
               FUNC_DEFRAG: begin
                  mem_req.raddr = '0;
                  state_in = S_D_CUR;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_A_RD: begin
            mem_req.raddr = SEG_IDX_W'(i_ff);
            state_in = S_A_CHK;
         end
         S_A_CHK: begin
            unique case (alloc_mode)
               MODE_FIRST: begin
                  better = qual;
                  done = qual;
               end
               MODE_BEST: begin
                  better = qual && (!found_ff || rdata.size < psize_ff);
                  done = better && (rdata.size == {1'b0, need_ff});
               end
               MODE_WORST: begin
                  better = qual && (!found_ff || rdata.size > psize_ff);
               end
               default: begin
                  done = qual;
               end
            endcase
            if (better) begin
               found_in = 1'b1;
               pick_in = i_ff;
               poff_in = rdata.offset;
               psize_in = rdata.size;
            end
            i_in = i_ff + 1'b1;
            if (done || i1 >= cnt1) begin
               if (better || found_ff && !(done && !better)) begin
                  state_in = S_A_DEC;
               end else begin
                  st_in = ST_NO_FIT;
                  state_in = S_RESP;
               end
            end else begin
               state_in = S_A_RD;
            end
         end
         S_A_DEC: begin
            res_in = 16'(17'(poff_ff) + HDR);
            if ((18'(psize_ff) >= 18'(need_ff) + 18'(HDR) + 18'd1) && (cnt1 < MAXC)) begin
               j_in = cnt_ff;
               if (cnt1 > (CW+1)'(pick_ff) + 1'b1) begin
                  state_in = S_A_SH_RD;
               end else begin
                  state_in = S_A_W1;
               end
            end else begin
               state_in = S_A_W2;
            end
         end
         S_A_SH_RD: begin
            mem_req.raddr = SEG_IDX_W'(j_ff - 1'b1);
            state_in = S_A_SH_WR;
         end
         S_A_SH_WR: begin
            mem_req.we = 1'b1;
            mem_req.waddr = SEG_IDX_W'(j_ff);
            mem_req.wdata = rdata;
            j_in = j_ff - 1'b1;
            if ((CW+1)'(j_ff) - 1'b1 > (CW+1)'(pick_ff) + 1'b1) begin
               state_in = S_A_SH_RD;
            end else begin
               state_in = S_A_W1;
            end
         end
         S_A_W1: begin
            wr.offset = 16'(17'(poff_ff) + HDR + 17'(need_ff));
            wr.size = psize_ff - 17'(need_ff) - HDR;
            wr.free = 1'b1;
            mem_req.we = 1'b1;
            mem_req.waddr = SEG_IDX_W'(pick_ff + 1'b1);
            mem_req.wdata = wr;
            psize_in = 17'(need_ff);
            cnt_in = cnt_ff + 1'b1;
            state_in = S_A_W2;
         end
         S_A_W2: begin
            wr.offset = poff_ff;
            wr.size = psize_ff;
            wr.free = 1'b0;
            mem_req.we = 1'b1;
            mem_req.waddr = SEG_IDX_W'(pick_ff);
            mem_req.wdata = wr;
            state_in = S_RESP;
         end
         S_F_RD: begin
            mem_req.raddr = SEG_IDX_W'(i_ff);
            state_in = S_F_CHK;
         end
         S_F_CHK: begin
            if (plus_hdr == 17'(addr_ff)) begin
               if (rdata.free) begin
                  st_in = ST_NOT_ALLOC;
                  state_in = S_RESP;
               end else begin
                  wr = rdata;
                  wr.free = 1'b1;
                  cur_in = wr;
                  mem_req.we = 1'b1;
                  mem_req.waddr = SEG_IDX_W'(i_ff);
                  mem_req.wdata = wr;
                  state_in = S_F_NXT;
               end
            end else if (i1 >= cnt1) begin
               st_in = ST_NOT_ALLOC;
               state_in = S_RESP;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = S_F_RD;
            end
         end
         S_F_NXT: begin
            if (i1 < cnt1) begin
               mem_req.raddr = SEG_IDX_W'(i_ff + 1'b1);
               state_in = S_F_NXT_CHK;
            end else begin
               state_in = S_F_PRV;
            end
         end
         S_F_NXT_CHK: begin
            state_in = S_F_PRV;
            if (rdata.free) begin
               wr = cur_ff;
               wr.size = cur_ff.size + HDR + rdata.size;
               cur_in = wr;
               mem_req.we = 1'b1;
               mem_req.waddr = SEG_IDX_W'(i_ff);
               mem_req.wdata = wr;
               j_in = i_ff + 1'b1;
               ret_in = S_F_PRV;
               state_in = S_DROP_RD;
            end
         end
         S_F_PRV: begin
            if (i_ff != '0) begin
               mem_req.raddr = SEG_IDX_W'(i_ff - 1'b1);
               state_in = S_F_PRV_CHK;
            end else begin
               state_in = S_RESP;
            end
         end
         S_F_PRV_CHK: begin
            state_in = S_RESP;
            if (rdata.free) begin
               wr = rdata;
               wr.size = rdata.size + HDR + cur_ff.size;
               mem_req.we = 1'b1;
               mem_req.waddr = SEG_IDX_W'(i_ff - 1'b1);
               mem_req.wdata = wr;
               j_in = i_ff;
               ret_in = S_RESP;
               state_in = S_DROP_RD;
            end
         end
         S_D_CUR: begin
            cur_in = rdata;
            state_in = S_D_LOOP;
         end
         S_D_LOOP: begin
            if (i1 >= cnt1) begin
               state_in = S_RESP;
            end else begin
               mem_req.raddr = SEG_IDX_W'(i_ff + 1'b1);
               state_in = S_D_CHK;
            end
         end
         S_D_CHK: begin
            if (cur_ff.free && rdata.free) begin
               wr = cur_ff;
               wr.size = cur_ff.size + HDR + rdata.size;
               cur_in = wr;
               mem_req.we = 1'b1;
               mem_req.waddr = SEG_IDX_W'(i_ff);
               mem_req.wdata = wr;
               j_in = i_ff + 1'b1;
               ret_in = S_D_LOOP;
               state_in = S_DROP_RD;
            end else begin
               cur_in = rdata;
               i_in = i_ff + 1'b1;
               state_in = S_D_LOOP;
            end
         end
         S_DROP_RD: begin
            if (j1 < cnt1) begin
               mem_req.raddr = SEG_IDX_W'(j_ff + 1'b1);
               state_in = S_DROP_WR;
            end else begin
               cnt_in = cnt_ff - 1'b1;
               state_in = ret_ff;
            end
         end
         S_DROP_WR: begin
            mem_req.we = 1'b1;
            mem_req.waddr = SEG_IDX_W'(j_ff);
            mem_req.wdata = rdata;
            j_in = j_ff + 1'b1;
            state_in = S_DROP_RD;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = st_ff;
               rsp_addr_in = (st_ff == ST_OK) ? res_ff : '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) && ((CW+1)'(cnt_ff) <= MAXC))
      else $error("segment count out of range");

   a_split_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_A_W1) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("split did not add a segment");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (state_ff == S_IDLE) && !pend_ff)
      else $error("item taken while busy");

   a_resp_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && (!rsp_valid_ff || rsp_tready)) |=> rsp_valid_ff)
      else $error("result lost");

endmodule
`default_nettype wire

/* hdl/fit_policy_heap_allocator.sv */
// Allocate scans the segment table and shifts entries up to make room on a split; free
// scans the table and shifts entries down on each merge; defragment walks every segment
// and shifts entries down on each merge. One item at a time, set by the sequential walk
// over the segment memory. A finished result waits in an output register. Reset
// (synchronous) and each heap_size write rebuild the table once the controller is idle.
`default_nettype none
module fit_policy_heap_allocator #(
   parameter int HEAP_BYTES = 65536,
   parameter int HEADER_BYTES = 16,
   parameter int MAX_SEGMENTS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [16:0] csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // func[1:0], req_size[17:2], addr[33:18]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata    // status[2:0], addr_res[18:3]
);
   import fpha_pkg::*;

   localparam logic [16:0] LIM = (HEAP_BYTES < 65536) ? 17'(HEAP_BYTES) : 17'd65536;
   localparam logic [16:0] HDR = 17'(HEADER_BYTES);

   logic [1:0] mode_ff;
   logic [16:0] heap_ff, heap_in;
   logic init_req;
   logic [2:0] status;
   logic [15:0] addr_res;
   mem_req_type mem_req;
   seg_type rdata;

   always_comb begin
      heap_in = csr_wdata;
      if (heap_in > LIM) begin
         heap_in = LIM;
      end
      if (heap_in < HDR) begin
         heap_in = HDR;
      end
   end

   assign init_req = csr_we && (csr_index == CSR_HEAP_SIZE);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_FIRST;
         heap_ff <= (LIM < HDR) ? HDR : LIM;
      end else if (csr_we) begin
         if (csr_index == CSR_ALLOC_MODE) begin
            mode_ff <= csr_wdata[1:0];
         end else if (csr_index == CSR_HEAP_SIZE) begin
            heap_ff <= heap_in;
         end
      end
   end

   fpha_ctrl #(
      .HEADER_BYTES(HEADER_BYTES),
      .MAX_SEGMENTS(MAX_SEGMENTS)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .init_req(init_req),
      .alloc_mode(mode_ff),
      .heap_size(heap_ff),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .func(req_tdata[1:0]),
      .req_size(req_tdata[17:2]),
      .addr(req_tdata[33:18]),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .status(status),
      .addr_res(addr_res),
      .mem_req(mem_req),
      .rdata(rdata)
   );

   fpha_seg_mem #(
      .DEPTH(MAX_SEGMENTS)
   ) u_mem (
      .clock(clock),
      .mem_req(mem_req),
      .rdata(rdata)
   );

   assign rsp_tdata = {5'd0, addr_res, status};

endmodule
`default_nettype wire

/* verif/fpha_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module fpha_checker #(
   parameter int HEAP_BYTES = 65536,
   parameter int HEADER_BYTES = 16,
   parameter int MAX_SEGMENTS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [16:0] csr_wdata,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [39:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [23:0] rsp_tdata,
   output int               fail_count,
   output int               pending
);
   import fpha_pkg::*;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] addr_res;
   } alloc_result_type;

   alloc_result_type expected_results[$];

   logic [1:0]  fit_mode;
   int          heap_bytes;
   logic [15:0] seg_off   [MAX_SEGMENTS];
   logic [16:0] seg_len   [MAX_SEGMENTS];
   bit          seg_avail [MAX_SEGMENTS];
   int          seg_total;

   assign pending = expected_results.size();

   function automatic void rebuild_heap(int bytes);
      int lim;
      lim = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;
      if (bytes > lim) bytes = lim;
      if (bytes < HEADER_BYTES) bytes = HEADER_BYTES;
      heap_bytes = bytes;
      for (int k = 0; k < MAX_SEGMENTS; k++) begin
         seg_off[k] = '0;
         seg_len[k] = '0;
         seg_avail[k] = 0;
      end
      seg_len[0] = 17'(bytes - HEADER_BYTES);
      seg_avail[0] = 1;
      seg_total = 1;
   endfunction

   function automatic void remove_seg(int k);
      for (int j = k; j + 1 < seg_total; j++) begin
         seg_off[j] = seg_off[j+1];
         seg_len[j] = seg_len[j+1];
         seg_avail[j] = seg_avail[j+1];
      end
      seg_total--;
      seg_off[seg_total] = '0;
      seg_len[seg_total] = '0;
      seg_avail[seg_total] = 0;
   endfunction

   function automatic void coalesce_next(int k);
      seg_len[k] = 17'(int'(seg_len[k]) + HEADER_BYTES + int'(seg_len[k+1]));
      remove_seg(k + 1);
   endfunction

   function automatic int choose_seg(int need);
      int pick;
      pick = -1;
      for (int i = 0; i < seg_total; i++) begin
         if (!seg_avail[i] || int'(seg_len[i]) < need) continue;
         if (fit_mode == MODE_FIRST) begin
            pick = i;
            break;
         end else if (fit_mode == MODE_BEST) begin
            if (pick < 0 || seg_len[i] < seg_len[pick]) begin
               pick = i;
               if (int'(seg_len[i]) == need) break;
            end
         end else if (fit_mode == MODE_WORST) begin
            if (pick < 0 || seg_len[i] > seg_len[pick]) pick = i;
         end else begin
            pick = -1;
            break;
         end
      end
      return pick;
   endfunction

   function automatic alloc_result_type apply_request(logic [1:0] func, int need, int addr);
      alloc_result_type r;
      int p;
      int i;
      r = '0;
      if (func == FUNC_ALLOC) begin
         if (need == 0) r.status = ST_BAD_SIZE;
         else begin
            p = choose_seg(need);
            if (p < 0) r.status = ST_NO_FIT;
            else begin
               if (int'(seg_len[p]) >= need + HEADER_BYTES + 1 && seg_total < MAX_SEGMENTS) begin
                  for (int j = seg_total; j > p + 1; j--) begin
                     seg_off[j] = seg_off[j-1];
                     seg_len[j] = seg_len[j-1];
                     seg_avail[j] = seg_avail[j-1];
                  end
                  seg_off[p+1] = 16'(int'(seg_off[p]) + HEADER_BYTES + need);
                  seg_len[p+1] = 17'(int'(seg_len[p]) - need - HEADER_BYTES);
                  seg_avail[p+1] = 1;
                  seg_total++;
                  seg_len[p] = 17'(need);
               end
               seg_avail[p] = 0;
               r.status = ST_OK;
               r.addr_res = 16'(int'(seg_off[p]) + HEADER_BYTES);
            end
         end
      end else if (func == FUNC_FREE) begin
         if (addr < HEADER_BYTES || addr >= heap_bytes) r.status = ST_RANGE;
         else begin
            for (i = 0; i < seg_total; i++)
               if (int'(seg_off[i]) + HEADER_BYTES == addr) break;
            if (i >= seg_total || seg_avail[i]) r.status = ST_NOT_ALLOC;
            else begin
               seg_avail[i] = 1;
               if (i + 1 < seg_total && seg_avail[i+1]) coalesce_next(i);
               if (i > 0 && seg_avail[i-1]) coalesce_next(i - 1);
            end
         end
      end else if (func == FUNC_DEFRAG) begin
         i = 0;
         while (i + 1 < seg_total) begin
            if (seg_avail[i] && seg_avail[i+1]) coalesce_next(i);
            else i++;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      alloc_result_type got;
      alloc_result_type want;
      if (reset) begin
         fit_mode <= MODE_FIRST;
         rebuild_heap(65536);
         expected_results.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_ALLOC_MODE) fit_mode <= csr_wdata[1:0];
            else if (csr_index == CSR_HEAP_SIZE) rebuild_heap(int'(csr_wdata));
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(apply_request(req_tdata[1:0],
               int'(req_tdata[17:2]), int'(req_tdata[33:18])));
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tdata[2:0];
            got.addr_res = rsp_tdata[18:3];
            if (expected_results.size() == 0) begin
               if (fail_count < 10) $display("unexpected item: status %0d addr %0d",
                  got.status, got.addr_res);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (got != want) begin
                  if (fail_count < 10)
                     $display("mismatch: expected status %0d addr %0d, got status %0d addr %0d",
                        want.status, want.addr_res, got.status, got.addr_res);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule
`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import fpha_pkg::*;

   localparam int WATCHDOG_LIMIT = 400000;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [1:0]  csr_index = '0;
   logic [16:0] csr_wdata = '0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // func[1:0], req_size[17:2], addr[33:18]
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;        // status[2:0], addr_res[18:3]

   int          fail_count;
   int          pending;
   bit          idling_on = 1;
   int          sent_items = 0;
   int          stall_left = 0;
   int          quiet_cycles = 0;
   logic [1:0]  sent_funcs[$];
   logic [15:0] live_blocks[$];

   always #1 clock = ~clock;

   fit_policy_heap_allocator dut (.*);

   fpha_checker u_checker (.*);

   always @(posedge clock) begin
      if (!reset && idling_on && stall_left == 0 && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(1, 12);
         rsp_tready <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else rsp_tready <= !reset;
   end

   always @(posedge clock) begin
      logic [1:0] f;
      if (rsp_tvalid && rsp_tready && sent_funcs.size() > 0) begin
         f = sent_funcs.pop_front();
         if (f == FUNC_ALLOC && rsp_tdata[2:0] == ST_OK) live_blocks.push_back(rsp_tdata[18:3]);
      end
      if (csr_we && csr_index == CSR_HEAP_SIZE) live_blocks.delete();
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [16:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      repeat (2) @(posedge clock);
   endtask

   task automatic send(logic [1:0] func, logic [15:0] size, logic [15:0] addr);
      req_tdata <= {6'b0, addr, size, func};
      req_tvalid <= 1;
      sent_funcs.push_back(func);
      do @(posedge clock); while (!req_tready);
      sent_items++;
      if (idling_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic send_random();
      int pick;
      int k;
      logic [15:0] a;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         if ($urandom_range(0, 19) == 0) send(FUNC_ALLOC, 16'($urandom), 16'd0);
         else if ($urandom_range(0, 49) == 0) send(FUNC_ALLOC, 16'd0, 16'($urandom));
         else send(FUNC_ALLOC, 16'($urandom_range(1, 300)), 16'($urandom));
      end else if (pick < 88 && live_blocks.size() > 0) begin
         k = $urandom_range(0, live_blocks.size() - 1);
         a = live_blocks[k];
         if ($urandom_range(0, 9) != 0) live_blocks.delete(k);
         send(FUNC_FREE, 16'($urandom), a);
      end else if (pick < 94) send(FUNC_FREE, 16'($urandom), 16'($urandom));
      else if (pick < 98) send(FUNC_DEFRAG, 16'($urandom), 16'($urandom));
      else send(FUNC_NOP, 16'($urandom), 16'($urandom));
   endtask

   initial begin
      logic [1:0]  modes[8] = '{MODE_FIRST, MODE_BEST, MODE_WORST, MODE_NONE,
                                MODE_BEST, MODE_FIRST, MODE_WORST, MODE_BEST};
      logic [16:0] heaps[8] = '{17'd65536, 17'd4096, 17'd1024, 17'd512,
                                17'd16, 17'h1FFFF, 17'd0, 17'd65536};
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      write_csr(CSR_ALLOC_MODE, MODE_FIRST);
      write_csr(CSR_HEAP_SIZE, 17'd65536);

      send(FUNC_ALLOC, 16'd0, 16'hFFFF);
      send(FUNC_ALLOC, 16'hFFFF, 16'd0);
      send(FUNC_ALLOC, 16'd65520, 16'd0);
      send(FUNC_FREE, 16'd0, 16'd16);
      send(FUNC_FREE, 16'd0, 16'd0);
      send(FUNC_FREE, 16'hFFFF, 16'hFFFF);
      send(FUNC_FREE, 16'd0, 16'd16);
      send(FUNC_NOP, 16'hFFFF, 16'hFFFF);
      send(FUNC_ALLOC, 16'd1, 16'd0);
      send(FUNC_ALLOC, 16'd1, 16'd0);
      send(FUNC_ALLOC, 16'd100, 16'd0);
      send(FUNC_FREE, 16'd0, 16'd16);
      send(FUNC_FREE, 16'd0, 16'd33);
      send(FUNC_FREE, 16'd0, 16'd20);
      send(FUNC_DEFRAG, 16'd0, 16'd0);
      send(FUNC_ALLOC, 16'd65503, 16'd0);
      send(FUNC_ALLOC, 16'd65504, 16'd0);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         write_csr(CSR_ALLOC_MODE, modes[ph]);
         write_csr(CSR_HEAP_SIZE, (ph == 6) ? 17'($urandom) : heaps[ph]);
         if (ph == 7) idling_on = 0;
         for (int n = 0; n < 250; n++) begin
            if (n == 125) drain();
            send_random();
         end
         req_tvalid <= 0;
         drain();
      end

      $display("Ran %0d items over all four fit policies and heap sizes from 16 to 65536 bytes,",
         sent_items);
      $display("including full tables, merges, defragment and invalid frees.");
      if (fail_count == 0 && pending == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
`default_nettype wire

/* files.f */
hdl/fpha_pkg.sv
hdl/fpha_seg_mem.sv
hdl/fpha_ctrl.sv
hdl/fit_policy_heap_allocator.sv
verif/fpha_checker.sv
verif/tb_top.sv
